[hw/rtl/text_console_writer_top_macros.svh]
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared assertion forms for the text console writer blocks.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, character codes, register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CMD_W      = 1;
  localparam int CHAR_W     = 8;
  localparam int RROW_W     = 6;
  localparam int RCOL_W     = 7;
  localparam int OROW_W     = 6;
  localparam int OCOL_W     = 8;
  localparam int NCOL_W     = 8;
  localparam int NROW_W     = 7;
  localparam int CROW_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  localparam logic [NCOL_W-1:0] NUM_COLUMNS_RST = 8'd80;
  localparam logic [NROW_W-1:0] NUM_ROWS_RST    = 7'd25;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_PUT   = 7'b0001000,
    ST_COPY  = 7'b0010000,
    ST_FILL  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } tcw_state_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CHAR,
    WR_COPY,
    WR_FILL,
    WR_CLEAR
  } wr_sel_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_CR,
    CUR_DOWN,
    CUR_ADV
  } cur_op_e;

  typedef enum logic [1:0] {
    SCAN_HOLD,
    SCAN_START,
    SCAN_NEXT
  } scan_op_e;

  typedef struct packed {
    logic     item_load;
    logic     rd_req;
    logic     rd_scan;
    wr_sel_e  wr_sel;
    cur_op_e  cur_op;
    scan_op_e scan_op;
    logic     out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_lf;
    logic is_cr;
    logic need_wrap;
    logic at_bottom;
    logic rows_one;
    logic scan_col_last;
    logic scan_row_last;
    logic clr_last;
  } tcw_sts_t;

endpackage

[hw/rtl/tcw_if.sv]
// ----------------------------------------------------------------------------
// Text console writer channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CHAR_W-1:0]   char_code;
  logic [RROW_W-1:0]   read_row;
  logic [RCOL_W-1:0]   read_column;

  modport source (output valid, command, char_code, read_row, read_column, input ready);
  modport sink   (input valid, command, char_code, read_row, read_column, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   cell_char;
  logic [OROW_W-1:0]   cursor_row_out;
  logic [OCOL_W-1:0]   cursor_column_out;

  modport source (output valid, cell_char, cursor_row_out, cursor_column_out, input ready);
  modport sink   (input valid, cell_char, cursor_row_out, cursor_column_out, output ready);
endinterface

[hw/rtl/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// Text console writer datapath
// Character memory with write stage, cursor, geometry registers, scan and
// clear counters, request latch and result register.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcw_cmd_t              cmd_i,
  output tcw_sts_t              sts_o,
  input  logic [CMD_W-1:0]      req_command_i,
  input  logic [CHAR_W-1:0]     req_char_code_i,
  input  logic [RROW_W-1:0]     req_read_row_i,
  input  logic [RCOL_W-1:0]     req_read_column_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [CHAR_W-1:0]     cell_char_o,
  output logic [OROW_W-1:0]     cursor_row_out_o,
  output logic [OCOL_W-1:0]     cursor_column_out_o
);

  localparam int COL_AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ADDR_W    = ROW_AW + COL_AW;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CMP_W     = NCOL_W + 1;

  function automatic logic [NCOL_W-1:0] clamp_cols(input logic [NCOL_W-1:0] n);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(n);
    if (n == '0) return NCOL_W'(1);
    if (wide > CMP_W'(MAX_COLUMNS)) return NCOL_W'(MAX_COLUMNS);
    return n;
  endfunction

  function automatic logic [NROW_W-1:0] clamp_rows(input logic [NROW_W-1:0] n);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(n);
    if (n == '0) return NROW_W'(1);
    if (wide > CMP_W'(MAX_ROWS)) return NROW_W'(MAX_ROWS);
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [CROW_W-1:0] r,
                                                input logic [OCOL_W-1:0] c);
    return {ROW_AW'(r), COL_AW'(c)};
  endfunction

  logic [CHAR_W-1:0] mem [MEM_DEPTH];

  logic [NCOL_W-1:0] ncol_q, ncol_d;
  logic [NROW_W-1:0] nrow_q, nrow_d;
  logic [CROW_W-1:0] row_q, row_d;
  logic [OCOL_W-1:0] col_q, col_d;
  logic [NCOL_W-1:0] cols, cols_new;
  logic [NROW_W-1:0] rows, rows_new;

  logic [CROW_W-1:0] scan_row_q, scan_row_d;
  logic [OCOL_W-1:0] scan_col_q, scan_col_d;
  logic [ADDR_W-1:0] clr_q;

  logic [CMD_W-1:0]  item_cmd_q;
  logic [CHAR_W-1:0] item_char_q;
  logic [RROW_W-1:0] item_rr_q;
  logic [RCOL_W-1:0] item_rc_q;

  logic              wp_v_q, wp_v_d;
  logic [ADDR_W-1:0] wp_addr_q, wp_addr_d;
  logic [CHAR_W-1:0] wp_data_q, wp_data_d;
  logic              wp_copy_q, wp_copy_d;
  logic [CHAR_W-1:0] wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rdata_q;

  logic              in_range;
  logic [CHAR_W-1:0] cell_data;
  logic [CHAR_W-1:0] out_cell_q;
  logic [OROW_W-1:0] out_row_q;
  logic [OCOL_W-1:0] out_col_q;

  assign cols     = clamp_cols(ncol_q);
  assign rows     = clamp_rows(nrow_q);
  assign cols_new = clamp_cols(cfg_wdata_i[NCOL_W-1:0]);
  assign rows_new = clamp_rows(cfg_wdata_i[NROW_W-1:0]);

  assign sts_o.is_read       = (item_cmd_q == CMD_READ);
  assign sts_o.is_lf         = (item_char_q == CHAR_LF);
  assign sts_o.is_cr         = (item_char_q == CHAR_CR);
  assign sts_o.need_wrap     = (col_q >= cols);
  assign sts_o.at_bottom     = ((CROW_W + 1)'(row_q) + 1'b1) >= (CROW_W + 1)'(rows);
  assign sts_o.rows_one      = (rows == NROW_W'(1));
  assign sts_o.scan_col_last = (scan_col_q == OCOL_W'(cols - NCOL_W'(1)));
  assign sts_o.scan_row_last = (scan_row_q == CROW_W'(rows - NROW_W'(1)));
  assign sts_o.clr_last      = &clr_q;

  always_comb begin
    ncol_d = ncol_q;
    nrow_d = nrow_q;
    row_d  = row_q;
    col_d  = col_q;
    case (cmd_i.cur_op)
      CUR_CR: begin
        col_d = '0;
      end
      CUR_DOWN: begin
        row_d = row_q + CROW_W'(1);
        col_d = '0;
      end
      CUR_ADV: begin
        col_d = col_q + OCOL_W'(1);
      end
      default: begin
      end
    endcase
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NUM_COLUMNS: begin
          ncol_d = cfg_wdata_i[NCOL_W-1:0];
          if (col_d > OCOL_W'(cols_new)) col_d = OCOL_W'(cols_new);
        end
        REG_NUM_ROWS: begin
          nrow_d = cfg_wdata_i[NROW_W-1:0];
          if (row_d >= CROW_W'(rows_new)) row_d = CROW_W'(rows_new - NROW_W'(1));
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    scan_row_d = scan_row_q;
    scan_col_d = scan_col_q;
    case (cmd_i.scan_op)
      SCAN_START: begin
        scan_row_d = CROW_W'(1);
        scan_col_d = '0;
      end
      SCAN_NEXT: begin
        if (sts_o.scan_col_last) begin
          scan_col_d = '0;
          scan_row_d = scan_row_q + CROW_W'(1);
        end else begin
          scan_col_d = scan_col_q + OCOL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wp_v_d    = 1'b1;
    wp_addr_d = clr_q;
    wp_data_d = CHAR_SPACE;
    wp_copy_d = 1'b0;
    case (cmd_i.wr_sel)
      WR_CHAR: begin
        wp_addr_d = mk_addr(row_q, col_q);
        wp_data_d = item_char_q;
      end
      WR_COPY: begin
        wp_addr_d = mk_addr(scan_row_q - CROW_W'(1), scan_col_q);
        wp_copy_d = 1'b1;
      end
      WR_FILL: begin
        wp_addr_d = mk_addr(CROW_W'(rows - NROW_W'(1)), scan_col_q);
      end
      WR_CLEAR: begin
      end
      default: begin
        wp_v_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd_i.rd_scan) begin
      rd_addr = mk_addr(scan_row_q, scan_col_q);
    end else if (cmd_i.rd_req) begin
      rd_addr = mk_addr(CROW_W'(req_read_row_i), OCOL_W'(req_read_column_i));
    end else begin
      rd_addr = mk_addr(CROW_W'(item_rr_q), OCOL_W'(item_rc_q));
    end
  end

  assign wdata = wp_copy_q ? rdata_q : wp_data_q;

  always_ff @(posedge clk_i) begin
    if (wp_v_q) begin
      mem[wp_addr_q] <= wdata;
    end
    if (wp_v_q && (wp_addr_q == rd_addr)) begin
      rdata_q <= wdata;
    end else begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncol_q     <= NUM_COLUMNS_RST;
      nrow_q     <= NUM_ROWS_RST;
      row_q      <= '0;
      col_q      <= '0;
      scan_row_q <= '0;
      scan_col_q <= '0;
      clr_q      <= '0;
      wp_v_q     <= 1'b0;
    end else begin
      ncol_q     <= ncol_d;
      nrow_q     <= nrow_d;
      row_q      <= row_d;
      col_q      <= col_d;
      scan_row_q <= scan_row_d;
      scan_col_q <= scan_col_d;
      wp_v_q     <= wp_v_d;
      if (cmd_i.wr_sel == WR_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  assign in_range = (CROW_W'(item_rr_q) < CROW_W'(rows)) &&
                    (OCOL_W'(item_rc_q) < OCOL_W'(cols));

  always_comb begin
    if (!sts_o.is_read) begin
      cell_data = CHAR_NONE;
    end else if (in_range) begin
      cell_data = rdata_q;
    end else begin
      cell_data = CHAR_SPACE;
    end
  end

  always_ff @(posedge clk_i) begin
    wp_addr_q <= wp_addr_d;
    wp_data_q <= wp_data_d;
    wp_copy_q <= wp_copy_d;
    if (cmd_i.item_load) begin
      item_cmd_q  <= req_command_i;
      item_char_q <= req_char_code_i;
      item_rr_q   <= req_read_row_i;
      item_rc_q   <= req_read_column_i;
    end
    if (cmd_i.out_load) begin
      out_cell_q <= cell_data;
      out_row_q  <= OROW_W'(row_d);
      out_col_q  <= col_d;
    end
  end

  assign cell_char_o         = out_cell_q;
  assign cursor_row_out_o    = out_row_q;
  assign cursor_column_out_o = out_col_q;

endmodule

[hw/rtl/tcw_controller.sv]
// ----------------------------------------------------------------------------
// Text console writer controller
// One-hot sequencer for clearing, request decode, scrolling and result
// handoff.
// ----------------------------------------------------------------------------
`include "text_console_writer_top_macros.svh"

module tcw_controller import tcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  input  tcw_sts_t sts_i,
  output tcw_cmd_t cmd_o
);

  tcw_state_e state_q, state_d;
  logic       put_after_q, put_after_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       slot_free;
  logic       accept;

  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d       = state_q;
    put_after_d   = put_after_q;
    cmd_o         = '0;
    cmd_o.wr_sel  = WR_NONE;
    cmd_o.cur_op  = CUR_HOLD;
    cmd_o.scan_op = SCAN_HOLD;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_sel = WR_CLEAR;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.rd_req = 1'b1;
        if (accept) begin
          cmd_o.item_load = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        if (sts_i.is_read) begin
          state_d = ST_DONE;
        end else if (sts_i.is_cr) begin
          cmd_o.cur_op = CUR_CR;
        end else if (sts_i.is_lf || sts_i.need_wrap) begin
          if (sts_i.at_bottom) begin
            cmd_o.cur_op  = CUR_CR;
            cmd_o.scan_op = SCAN_START;
            put_after_d   = !sts_i.is_lf;
            state_d       = sts_i.rows_one ? ST_FILL : ST_COPY;
          end else begin
            cmd_o.cur_op = CUR_DOWN;
            if (!sts_i.is_lf) state_d = ST_PUT;
          end
        end else begin
          cmd_o.wr_sel = WR_CHAR;
          cmd_o.cur_op = CUR_ADV;
        end
        if (state_d == ST_DONE && slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_PUT: begin
        cmd_o.wr_sel = WR_CHAR;
        cmd_o.cur_op = CUR_ADV;
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_COPY: begin
        cmd_o.rd_scan = 1'b1;
        cmd_o.wr_sel  = WR_COPY;
        cmd_o.scan_op = SCAN_NEXT;
        if (sts_i.scan_col_last && sts_i.scan_row_last) state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.wr_sel  = WR_FILL;
        cmd_o.scan_op = SCAN_NEXT;
        if (sts_i.scan_col_last) state_d = put_after_q ? ST_PUT : ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.out_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      put_after_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      put_after_q <= put_after_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  `TCW_ASSERT_NOW(a_load_into_free_slot, cmd_o.out_load, !rsp_valid_q || rsp_ready_i, "result overwritten")
  `TCW_ASSERT_NEXT(a_accept_to_exec, accept, state_q == ST_EXEC, "accepted request not decoded")
  `TCW_ASSERT_NOW(a_scroll_at_bottom, state_q == ST_EXEC && cmd_o.scan_op == SCAN_START, sts_i.at_bottom, "scroll off bottom row")
  `TCW_ASSERT_NEXT(a_fill_exit, state_q == ST_FILL, state_q == ST_FILL || state_q == ST_PUT || state_q == ST_DONE, "bad fill exit")
  `TCW_ASSERT_NEXT(a_load_sets_valid, cmd_o.out_load, rsp_valid_q, "loaded result not presented")

endmodule

[hw/rtl/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console with a character grid, a cursor and scroll-up. A request
// writes one byte at the cursor (line feed, carriage return, wrap) or reads
// one cell; each request returns one result with the cell and the cursor.
// A scroll walks the character memory one cell per cycle (one read and one write
// each cycle), copying each row up and then filling the bottom row with spaces.
// After reset every address of the memory is swept to spaces, during which no
// request is taken; register writes are taken at any time. The next request is
// taken while a result waits on the output register.
// ----------------------------------------------------------------------------
module text_console_writer_top import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcw_req_if.sink               req_i,
  tcw_rsp_if.source             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .req_command_i       (req_i.command),
    .req_char_code_i     (req_i.char_code),
    .req_read_row_i      (req_i.read_row),
    .req_read_column_i   (req_i.read_column),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .cell_char_o         (rsp_o.cell_char),
    .cursor_row_out_o    (rsp_o.cursor_row_out),
    .cursor_column_out_o (rsp_o.cursor_column_out)
  );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives write and read requests into the console, predicts each result
// (cell, cursor row, cursor column) from a behavioral copy of the grid and
// cursor, and compares every result in order. A short directed table opens
// the run, followed by random phases over many grid geometries, including
// out-of-range and largest ones, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top import tcw_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CON_COLS = 128;
  localparam int CON_ROWS = 64;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_column;
  } console_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [OROW_W-1:0] cursor_row;
    logic [OCOL_W-1:0] cursor_col;
  } console_rsp_t;

  typedef enum logic {STEP_REQ, STEP_REG} step_kind_e;

  typedef struct {
    step_kind_e            kind;
    console_req_t          rq;
    bit                    typed;
    console_rsp_t          want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } dir_step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tcw_req_if req_if();
  tcw_rsp_if rsp_if();

  text_console_writer_top #(
    .MAX_COLUMNS(CON_COLS),
    .MAX_ROWS   (CON_ROWS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Behavioral copy of the console
  logic [CHAR_W-1:0] screen_mem [CON_ROWS*CON_COLS];
  logic [OROW_W-1:0] cur_row;
  logic [OCOL_W-1:0] cur_col;
  logic [NCOL_W-1:0] num_cols;
  logic [NROW_W-1:0] num_rows;

  console_rsp_t console_results_q [$];
  dir_step_t    dir_steps [$];
  int           mismatch_count;
  int           n_random;
  bit           no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int used_cols();
    if (num_cols == '0) return 1;
    if (int'(num_cols) > CON_COLS) return CON_COLS;
    return int'(num_cols);
  endfunction

  function automatic int used_rows();
    if (num_rows == '0) return 1;
    if (int'(num_rows) > CON_ROWS) return CON_ROWS;
    return int'(num_rows);
  endfunction

  function automatic void clamp_cursor();
    if (int'(cur_row) >= used_rows()) cur_row = OROW_W'(used_rows() - 1);
    if (int'(cur_col) > used_cols()) cur_col = OCOL_W'(used_cols());
  endfunction

  function automatic void scroll_up();
    int rows_n;
    int cols_n;
    rows_n = used_rows();
    cols_n = used_cols();
    for (int r = 1; r < rows_n; r++) begin
      for (int c = 0; c < cols_n; c++) begin
        screen_mem[(r-1)*CON_COLS + c] = screen_mem[r*CON_COLS + c];
      end
    end
    for (int c = 0; c < cols_n; c++) screen_mem[(rows_n-1)*CON_COLS + c] = CHAR_SPACE;
  endfunction

  function automatic void new_line();
    cur_col = '0;
    if (int'(cur_row) + 1 >= used_rows()) begin
      cur_row = OROW_W'(used_rows() - 1);
      scroll_up();
    end else begin
      cur_row = cur_row + 1'b1;
    end
  endfunction

  function automatic void put_char(input logic [CHAR_W-1:0] ch);
    clamp_cursor();
    if (ch == CHAR_LF) begin
      new_line();
    end else if (ch == CHAR_CR) begin
      cur_col = '0;
    end else begin
      if (int'(cur_col) >= used_cols()) new_line();
      screen_mem[int'(cur_row)*CON_COLS + int'(cur_col)] = ch;
      cur_col = cur_col + 1'b1;
    end
  endfunction

  function automatic console_rsp_t console_step(input console_req_t rq);
    console_rsp_t res;
    res.cell_char = CHAR_NONE;
    if (rq.command == CMD_WRITE) begin
      put_char(rq.char_code);
    end else if (int'(rq.read_row) < used_rows() && int'(rq.read_column) < used_cols()) begin
      res.cell_char = screen_mem[int'(rq.read_row)*CON_COLS + int'(rq.read_column)];
    end else begin
      res.cell_char = CHAR_SPACE;
    end
    res.cursor_row = cur_row;
    res.cursor_col = cur_col;
    return res;
  endfunction

  function automatic void set_geometry(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_NUM_COLUMNS) num_cols = val;
    else if (idx == REG_NUM_ROWS) num_rows = val[NROW_W-1:0];
    clamp_cursor();
  endfunction

  function automatic console_req_t write_request(input logic [CHAR_W-1:0] ch);
    console_req_t rq;
    rq.command     = CMD_WRITE;
    rq.char_code   = ch;
    rq.read_row    = RROW_W'($urandom);
    rq.read_column = RCOL_W'($urandom);
    return rq;
  endfunction

  function automatic console_req_t random_request();
    console_req_t rq;
    int           pick;
    pick = $urandom_range(0, 99);
    rq = write_request(CHAR_W'($urandom_range(32, 126)));
    if (pick < 22) begin
      rq.command   = CMD_READ;
      rq.char_code = CHAR_W'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        rq.read_row    = RROW_W'($urandom_range(0, used_rows() - 1));
        rq.read_column = RCOL_W'($urandom_range(0, used_cols() - 1));
      end
    end else if (pick < 30) begin
      rq.char_code = CHAR_LF;
    end else if (pick < 35) begin
      rq.char_code = CHAR_CR;
    end else if (pick < 45) begin
      rq.char_code = CHAR_W'($urandom_range(0, 255));
    end
    return rq;
  endfunction

  function automatic void dir_req(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                  input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc,
                                  input bit typed = 1'b0,
                                  input logic [CHAR_W-1:0] want_cell = '0,
                                  input logic [OROW_W-1:0] row = '0,
                                  input logic [OCOL_W-1:0] col = '0);
    dir_step_t s;
    s.kind              = STEP_REQ;
    s.rq.command        = cmd;
    s.rq.char_code      = ch;
    s.rq.read_row       = rr;
    s.rq.read_column    = rc;
    s.typed             = typed;
    s.want.cell_char    = want_cell;
    s.want.cursor_row   = row;
    s.want.cursor_col   = col;
    s.reg_idx           = '0;
    s.reg_val           = '0;
    dir_steps.push_back(s);
  endfunction

  function automatic void dir_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    dir_step_t s;
    s.kind    = STEP_REG;
    s.rq      = '0;
    s.typed   = 1'b0;
    s.want    = '0;
    s.reg_idx = idx;
    s.reg_val = val;
    dir_steps.push_back(s);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic send_request(input console_req_t rq, input bit typed,
                              input console_rsp_t want);
    console_rsp_t got;
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(0, 99) < 19) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= rq.command;
    req_if.char_code   <= rq.char_code;
    req_if.read_row    <= rq.read_row;
    req_if.read_column <= rq.read_column;
    do @(posedge clk_i); while (!req_if.ready);
    got = console_step(rq);
    console_results_q.push_back(typed ? want : got);
  endtask

  task automatic send_counted(input console_req_t rq);
    no_gaps = (n_random >= 250 && n_random < 400);
    send_request(rq, 1'b0, '0);
    n_random++;
  endtask

  // Hold requests until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (console_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    set_geometry(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    rsp_if.ready <= no_gaps || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk_i) begin
    console_rsp_t exp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (console_results_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp = console_results_q.pop_front();
        if (rsp_if.cell_char !== exp.cell_char)
          report_mismatch($sformatf("cell_char %0h, want %0h", rsp_if.cell_char,
                                    exp.cell_char));
        if (rsp_if.cursor_row_out !== exp.cursor_row)
          report_mismatch($sformatf("cursor_row_out %0d, want %0d", rsp_if.cursor_row_out,
                                    exp.cursor_row));
        if (rsp_if.cursor_column_out !== exp.cursor_col)
          report_mismatch($sformatf("cursor_column_out %0d, want %0d",
                                    rsp_if.cursor_column_out, exp.cursor_col));
      end
    end
  end

  initial begin
    #200_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int                    phase;
    int                    span;
    logic [CFG_DATA_W-1:0] cols_val;
    logic [CFG_DATA_W-1:0] rows_val;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = REG_NUM_COLUMNS;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.command     = CMD_WRITE;
    req_if.char_code   = '0;
    req_if.read_row    = '0;
    req_if.read_column = '0;
    rsp_if.ready       = 1'b0;
    mismatch_count     = 0;
    n_random           = 0;
    no_gaps            = 1'b0;
    for (int i = 0; i < CON_ROWS*CON_COLS; i++) screen_mem[i] = CHAR_SPACE;
    cur_row  = '0;
    cur_col  = '0;
    num_cols = NUM_COLUMNS_RST;
    num_rows = NUM_ROWS_RST;

    // Default 80x25 grid, then a 3x2 grid with wrap and scroll, then 1x1
    dir_req(CMD_READ,  8'hFF, 6'd0,  7'd0,   1'b1, CHAR_SPACE, 6'd0, 8'd0);
    dir_req(CMD_READ,  8'h00, 6'd63, 7'd127, 1'b1, CHAR_SPACE, 6'd0, 8'd0);
    dir_req(CMD_WRITE, "A",   6'd63, 7'd127, 1'b1, CHAR_NONE,  6'd0, 8'd1);
    dir_req(CMD_WRITE, 8'h00, 6'd0,  7'd0,   1'b1, CHAR_NONE,  6'd0, 8'd2);
    dir_req(CMD_WRITE, 8'hFF, 6'd21, 7'd85,  1'b1, CHAR_NONE,  6'd0, 8'd3);
    dir_req(CMD_READ,  8'h55, 6'd0,  7'd0,   1'b1, "A",        6'd0, 8'd3);
    dir_req(CMD_READ,  8'hAA, 6'd0,  7'd1,   1'b1, 8'h00,      6'd0, 8'd3);
    dir_req(CMD_READ,  8'h00, 6'd0,  7'd2,   1'b1, 8'hFF,      6'd0, 8'd3);
    dir_req(CMD_WRITE, CHAR_CR, 6'd42, 7'd42, 1'b1, CHAR_NONE, 6'd0, 8'd0);
    dir_req(CMD_WRITE, CHAR_LF, 6'd0,  7'd0,  1'b1, CHAR_NONE, 6'd1, 8'd0);
    dir_req(CMD_READ,  8'h00, 6'd24, 7'd79,  1'b1, CHAR_SPACE, 6'd1, 8'd0);
    dir_req(CMD_READ,  8'h00, 6'd25, 7'd0,   1'b1, CHAR_SPACE, 6'd1, 8'd0);
    dir_req(CMD_READ,  8'h00, 6'd0,  7'd80,  1'b1, CHAR_SPACE, 6'd1, 8'd0);
    dir_reg(REG_NUM_COLUMNS, 8'd3);
    dir_reg(REG_NUM_ROWS,    8'd2);
    dir_req(CMD_WRITE, "x",   6'd0,  7'd0,   1'b1, CHAR_NONE,  6'd1, 8'd1);
    dir_req(CMD_WRITE, "y",   6'd0,  7'd0);
    dir_req(CMD_WRITE, "z",   6'd0,  7'd0,   1'b1, CHAR_NONE,  6'd1, 8'd3);
    dir_req(CMD_WRITE, "w",   6'd0,  7'd0,   1'b1, CHAR_NONE,  6'd1, 8'd1);
    dir_req(CMD_READ,  8'h00, 6'd0,  7'd0,   1'b1, "x",        6'd1, 8'd1);
    dir_req(CMD_READ,  8'h00, 6'd1,  7'd0,   1'b1, "w",        6'd1, 8'd1);
    dir_reg(REG_NUM_COLUMNS, 8'd0);
    dir_reg(REG_NUM_ROWS,    8'd0);
    dir_req(CMD_WRITE, "k",   6'd0,  7'd0,   1'b1, CHAR_NONE,  6'd0, 8'd1);
    dir_req(CMD_READ,  8'h00, 6'd0,  7'd0,   1'b1, "k",        6'd0, 8'd1);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_REG) begin
        drain_results();
        write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
      end else begin
        send_request(dir_steps[i].rq, dir_steps[i].typed, dir_steps[i].want);
      end
    end

    phase = 0;
    while (n_random < 750) begin
      case (phase)
        0:       begin cols_val = 8'd128; rows_val = 8'd64;  end
        1:       begin cols_val = 8'd255; rows_val = 8'hFF;  end
        2:       begin cols_val = 8'd0;   rows_val = 8'd0;   end
        3:       begin cols_val = 8'd80;  rows_val = 8'd25;  end
        4:       begin cols_val = 8'd129; rows_val = 8'h80;  end
        default: begin
          cols_val = CFG_DATA_W'($urandom_range(1, 12));
          rows_val = CFG_DATA_W'($urandom_range(1, 6));
          if ($urandom_range(0, 9) == 0) cols_val = $urandom_range(0, 1) ? 8'd0 : 8'd255;
          if ($urandom_range(0, 9) == 0) rows_val = $urandom_range(0, 1) ? 8'd0 : 8'd127;
        end
      endcase
      drain_results();
      if (phase < 5 || $urandom_range(0, 3) != 0) write_reg(REG_NUM_COLUMNS, cols_val);
      if (phase < 5 || $urandom_range(0, 3) != 0) write_reg(REG_NUM_ROWS, rows_val);

      if (phase == 0)
        repeat (used_cols() + 2) send_counted(write_request(CHAR_W'($urandom_range(32, 126))));
      if (phase == 1) repeat (used_rows() + 1) send_counted(write_request(CHAR_LF));

      span = $urandom_range(30, 60);
      repeat (span) send_counted(random_request());

      if (phase > 4 && $urandom_range(0, 2) == 0)
        repeat (used_cols() + 1) send_counted(write_request(CHAR_W'($urandom_range(33, 126))));
      phase++;
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_datapath.sv
hw/rtl/tcw_controller.sv
hw/rtl/text_console_writer_top.sv
tb/tb_top.sv
